// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the buffer cache RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bbc_pkg.sv
// Shared types, constants and helpers of the buffer cache directory.
// No dependencies.
`default_nettype none

package bbc_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int OUT_IDX_W = 6;

  localparam logic [7:0] RC_MAX = 8'hFF;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PIN     = 2'd2;
  localparam logic [1:0] OP_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic        vld;
    logic [7:0]  rc;
    logic [31:0] rtime;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clr;
    logic en;
  } scan_ctl_t;

  typedef struct packed {
    logic   found;
    idx_t   match_idx;
    entry_t match_ent;
    logic   have_free;
    idx_t   best_idx;
    logic [31:0] best_time;
  } scan_res_t;

  // Contents of an entry that has not been written since reset.
  function automatic entry_t reset_entry(idx_t i);
    entry_t e;
    logic [IDX_W+31:0] wide;
    wide = {32'd0, i};
    e.dev = 8'd0;
    e.blk = wide[31:0];
    e.vld = 1'b0;
    e.rc = 8'd0;
    e.rtime = 32'd0;
    return e;
  endfunction

  function automatic logic [OUT_IDX_W-1:0] to_out_idx(idx_t i);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, i};
    return wide[OUT_IDX_W-1:0];
  endfunction

  function automatic idx_t from_in_idx(logic [OUT_IDX_W-1:0] i);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, i};
    return wide[IDX_W-1:0];
  endfunction

  function automatic logic [7:0] rc_inc(logic [7:0] rc);
    return (rc == RC_MAX) ? rc : rc + 8'd1;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bbc_scan.sv
// Shared compare unit of the directory scan: tag match and oldest free entry.
// Depends on bbc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bbc_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bbc_pkg::scan_ctl_t ctl,
  input  wire bbc_pkg::entry_t   ent,
  input  wire bbc_pkg::idx_t     ent_idx,
  input  wire logic [7:0]        dev,
  input  wire logic [31:0]       blk,
  output bbc_pkg::scan_res_t     res
);
  import bbc_pkg::*;

  logic tag_eq;
  logic is_free;
  logic older;

  // one entry per cycle goes through these compares
  assign tag_eq  = (ent.dev == dev) && (ent.blk == blk);
  assign is_free = (ent.rc == 8'd0);
  assign older   = (ent.rtime < res.best_time);

  // running picks: first tag match, oldest free entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res.found <= 1'b0;
      res.have_free <= 1'b0;
    end else if (ctl.clr) begin
      res.found <= 1'b0;
      res.have_free <= 1'b0;
    end else if (ctl.en) begin
      if (tag_eq && !res.found) begin
        res.found <= 1'b1;
        res.match_idx <= ent_idx;
        res.match_ent <= ent;
      end
      // strict less-than keeps the lowest index on ties
      if (is_free && (!res.have_free || older)) begin
        res.have_free <= 1'b1;
        res.best_idx <= ent_idx;
        res.best_time <= ent.rtime;
      end
    end
  end

  `ASSERT_RST(a_found_sticky, clk, rst, (res.found && !ctl.clr) |=> res.found, "match lost mid-scan")

endmodule

`default_nettype wire

// File: hw/rtl/block_buffer_cache_lru.sv
// Top level of the disk block buffer cache directory with timestamp LRU.
// Depends on bbc_pkg, bbc_ram, bbc_scan and assert_macros.svh.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  req     | in  | req_valid / req_ready | op, device, block_number, buffer_index,
//          |     |                       | now_tick
//  rsp     | out | rsp_valid / rsp_ready | entry_index, hit, needs_fill, status
//
// A read walks all NUM_ENTRIES entries through one RAM read port and the shared
// compare unit, one entry a cycle, then passes a drain step into the final step,
// which updates the picked entry, if any, and registers the result; a new item is
// taken only back in idle. Release, pin and unpin read one entry and write it back
// in the final step; with buffer_index out of range they skip the read and write.
// Reset is synchronous; a flop per entry marks entries written since reset,
// and an unwritten entry reads as its reset value, so no clearing pass runs.
// req_ready is high only in idle; a result waiting on rsp_ready holds the
// sequencer in its final step, and no next item is taken while it waits.
`default_nettype none
`include "assert_macros.svh"

module block_buffer_cache_lru (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire logic [1:0]                       op,
  input  wire logic [7:0]                       device,
  input  wire logic [31:0]                      block_number,
  input  wire logic [5:0]                       buffer_index,
  input  wire logic [31:0]                      now_tick,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic [5:0]                            entry_index,
  output logic                                  hit,
  output logic                                  needs_fill,
  output logic [1:0]                            status
);
  import bbc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam idx_t LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  logic [2:0] state;
  logic [2:0] state_next;

  // latched request
  logic [1:0]  op_q;
  logic [7:0]  dev_q;
  logic [31:0] blk_q;
  idx_t        idx_q;
  logic        oor_q;
  logic [31:0] now_q;
  // out-of-range index: report the requested index as given
  logic [5:0]  oor_idx_q;

  idx_t cnt;
  logic rd_vq;
  idx_t rd_addr_q;
  logic [NUM_ENTRIES-1:0] written;
  entry_t ent_q;

  logic accept;
  logic in_range;
  logic rd_en;
  idx_t rd_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t ram_ent;
  entry_t view;

  scan_ctl_t scan_ctl;
  scan_res_t scan_res;

  logic   fin_go;
  logic   we;
  idx_t   waddr;
  entry_t wdata;
  logic [OUT_IDX_W-1:0] r_idx;
  logic   r_hit;
  logic   r_fill;
  logic [1:0] r_status;
  logic [7:0] rc_dec;

  assign accept   = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign in_range = ({26'd0, buffer_index} < 32'(NUM_ENTRIES));

  // single RAM read port: the request's entry on accept, else the scan counter
  assign rd_en   = (accept && (op != OP_READ) && in_range) || (state == S_SCAN);
  assign rd_addr = (state == S_SCAN) ? cnt : from_in_idx(buffer_index);

  bbc_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign ram_ent = ram_rdata;
  // never-written entries read as their reset contents
  assign view = written[rd_addr_q] ? ram_ent : reset_entry(rd_addr_q);

  assign scan_ctl.clr = accept;
  assign scan_ctl.en  = rd_vq && (op_q == OP_READ);

  bbc_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .ent     (view),
    .ent_idx (rd_addr_q),
    .dev     (dev_q),
    .blk     (blk_q),
    .res     (scan_res)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_READ) begin
            state_next = S_SCAN;
          end else if (!in_range) begin
            state_next = S_FIN;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_SCAN: begin
        if (cnt == LAST_IDX) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_FIN;
      S_RD:    state_next = S_FIN;
      S_FIN: begin
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_vq <= 1'b0;
      written <= '0;
    end else begin
      state <= state_next;
      rd_vq <= rd_en;
      if (we) begin
        written[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op;
      dev_q     <= device;
      blk_q     <= block_number;
      idx_q     <= from_in_idx(buffer_index);
      oor_q     <= !in_range;
      oor_idx_q <= buffer_index;
      now_q     <= now_tick;
      cnt       <= '0;
    end else if (state == S_SCAN) begin
      cnt <= cnt + idx_t'(1);
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (state == S_RD) begin
      ent_q <= view;
    end
  end

  // final step: entry update and result
  assign fin_go = !rsp_valid || rsp_ready;
  assign rc_dec = ent_q.rc - 8'd1;

  always_comb begin
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = ent_q;
    r_idx    = to_out_idx(idx_q);
    r_hit    = 1'b0;
    r_fill   = 1'b0;
    r_status = ST_OK;
    if (op_q == OP_READ) begin
      if (scan_res.found) begin
        we        = 1'b1;
        waddr     = scan_res.match_idx;
        wdata     = scan_res.match_ent;
        wdata.rc  = rc_inc(scan_res.match_ent.rc);
        wdata.vld = 1'b1;
        r_idx     = to_out_idx(scan_res.match_idx);
        r_hit     = 1'b1;
        r_fill    = !scan_res.match_ent.vld;
      end else if (scan_res.have_free) begin
        we          = 1'b1;
        waddr       = scan_res.best_idx;
        wdata.dev   = dev_q;
        wdata.blk   = blk_q;
        wdata.vld   = 1'b1;
        wdata.rc    = 8'd1;
        wdata.rtime = scan_res.best_time;
        r_idx       = to_out_idx(scan_res.best_idx);
        r_fill      = 1'b1;
      end else begin
        r_idx    = '0;
        r_status = ST_FULL;
      end
    end else if (oor_q) begin
      r_idx = oor_idx_q;
    end else if (op_q == OP_PIN) begin
      we       = 1'b1;
      wdata.rc = rc_inc(ent_q.rc);
    end else if (ent_q.rc == 8'd0) begin
      r_status = ST_UNDER;
    end else begin
      we       = 1'b1;
      wdata.rc = rc_dec;
      if ((op_q == OP_RELEASE) && (rc_dec == 8'd0)) begin
        wdata.rtime = now_q;
      end
    end
    we = we && (state == S_FIN) && fin_go;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_FIN) && fin_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && fin_go) begin
      entry_index <= r_idx;
      hit         <= r_hit;
      needs_fill  <= r_fill;
      status      <= r_status;
    end
  end

  `ASSERT_RST(a_we_in_fin, clk, rst, we |-> (state == S_FIN), "RAM write outside final step")
  `ASSERT_RST(a_busy_after_accept, clk, rst, accept |=> !req_ready, "item taken while busy")
  `ASSERT_RST(a_hit_ok, clk, rst, (rsp_valid && hit) |-> (status == ST_OK), "hit with bad status")
  `ASSERT_ALW(a_scan_reads, clk, (state == S_SCAN) |-> rd_en, "scan step without RAM read")

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking bench for block_buffer_cache_lru: directed and random item traffic
// checked against an in-bench model of the cache directory.
// Depends on bbc_pkg and the block_buffer_cache_lru RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int ITEMS       = 1250;      // stimulus stops once this many are queued
  localparam int CYCLE_LIMIT = 1000000;   // far beyond the slowest legal run
  localparam int MIX_LEN     = 40;        // items per mixed traffic phase

  // One request item and one response item as the bench sees them.
  typedef struct {
    logic [1:0]  op;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [5:0]  idx;
    logic [31:0] tick;
  } cache_req_t;

  typedef struct {
    logic [5:0] entry;
    logic       hit;
    logic       fill;
    logic [1:0] st;
  } cache_rsp_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        req_valid    = 1'b0;
  logic        req_ready;
  logic [1:0]  op           = OP_READ;
  logic [7:0]  device       = '0;
  logic [31:0] block_number = '0;
  logic [5:0]  buffer_index = '0;
  logic [31:0] now_tick     = '0;
  logic        rsp_valid;
  logic        rsp_ready    = 1'b0;
  logic [5:0]  entry_index;
  logic        hit;
  logic        needs_fill;
  logic [1:0]  status;

  block_buffer_cache_lru DUT (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .op           (op),
    .device       (device),
    .block_number (block_number),
    .buffer_index (buffer_index),
    .now_tick     (now_tick),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .entry_index  (entry_index),
    .hit          (hit),
    .needs_fill   (needs_fill),
    .status       (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Directory model. Advanced by the monitor in request acceptance order, so
  // its state always matches what the DUT has seen so far.
  // ---------------------------------------------------------------------------
  logic [7:0]  tag_dev  [NUM_ENTRIES];
  logic [31:0] tag_blk  [NUM_ENTRIES];
  logic        ent_vld  [NUM_ENTRIES];
  logic [7:0]  ref_cnt  [NUM_ENTRIES];
  logic [31:0] rel_time [NUM_ENTRIES];

  cache_rsp_t  due_rsp_q [$];   // responses owed by the DUT, oldest first
  cache_req_t  req_q     [$];   // items waiting for the driver

  int n_items;                  // items queued so far
  int n_checked;                // responses consumed (nonblocking, read by other blocks)
  int err_cnt;
  int n_hit, n_fill, n_full, n_under, n_sat;
  int cycle_cnt;
  logic [31:0] cur_tick;

  // Applies one item to the model and returns the response it must produce.
  function automatic cache_rsp_t directory_step(cache_req_t r);
    cache_rsp_t  rsp;
    int          pick;
    bit          found;
    bit          have_free;
    logic [31:0] best_t;
    rsp.entry = r.idx;
    rsp.hit   = 1'b0;
    rsp.fill  = 1'b0;
    rsp.st    = ST_OK;
    pick      = 0;
    found     = 1'b0;
    have_free = 1'b0;
    best_t    = '0;
    if (r.op == OP_READ) begin
      // tags match whether or not the entry holds valid data
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (!found && tag_dev[i] == r.dev && tag_blk[i] == r.blk) begin
          found = 1'b1;
          pick  = i;
        end
      end
      if (found) begin
        rsp.entry = 6'(pick);
        rsp.hit   = 1'b1;
        rsp.fill  = !ent_vld[pick];
        if (ref_cnt[pick] == RC_MAX) n_sat++;
        else ref_cnt[pick]++;
        ent_vld[pick] = 1'b1;
      end else begin
        // oldest free entry, strict compare keeps the lowest index on ties
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (ref_cnt[i] == 8'd0 && (!have_free || rel_time[i] < best_t)) begin
            have_free = 1'b1;
            best_t    = rel_time[i];
            pick      = i;
          end
        end
        if (!have_free) begin
          rsp.entry = '0;
          rsp.st    = ST_FULL;
        end else begin
          tag_dev[pick] = r.dev;
          tag_blk[pick] = r.blk;
          ref_cnt[pick] = 8'd1;
          ent_vld[pick] = 1'b1;
          rsp.entry     = 6'(pick);
          rsp.fill      = 1'b1;
        end
      end
    end else if (int'(r.idx) < NUM_ENTRIES) begin
      if (r.op == OP_PIN) begin
        if (ref_cnt[r.idx] == RC_MAX) n_sat++;
        else ref_cnt[r.idx]++;
      end else if (ref_cnt[r.idx] == 8'd0) begin
        rsp.st = ST_UNDER;            // no change, no stamp
      end else begin
        ref_cnt[r.idx]--;
        if (r.op == OP_RELEASE && ref_cnt[r.idx] == 8'd0) rel_time[r.idx] = r.tick;
      end
    end
    return rsp;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (err_cnt < 10)
        $display("MISMATCH %s on response %0d: expected %0d, got %0d",
                 name, n_checked, want, got);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pops queued items, offers them in bursts with random gaps. Valid is
  // only touched when the slot is free, so an offered item never changes.
  // ---------------------------------------------------------------------------
  int gap_left;
  int burst_left;

  always @(posedge clk) begin
    cache_req_t nxt;
    if (rst) begin
      req_valid  <= 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else if (!req_valid || req_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        op           <= nxt.op;
        device       <= nxt.dev;
        block_number <= nxt.blk;
        buffer_index <= nxt.idx;
        now_tick     <= nxt.tick;
        req_valid    <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a quarter of the bursts run straight into the next one
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rotating stall pattern, re-drawn at the start of each epoch (sometimes all
  // ready). Twice it holds off for a long stretch while the driver is still
  // offering, so the DUT's result slot and then its input back up.
  // ---------------------------------------------------------------------------
  int          hold_left;
  int          holds_done;
  int          epoch;
  logic [15:0] stall_pat;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b0;
      hold_left  = 0;
      holds_done = 0;
      epoch      = 0;
      stall_pat  = 16'hFFFF;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (holds_done < 2 && req_valid &&
                 n_checked >= ((holds_done == 0) ? 150 : 700)) begin
      hold_left = (holds_done == 0) ? 400 : 250;
      holds_done++;
      rsp_ready <= 1'b0;
    end else begin
      if (epoch == 0)
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      epoch = (epoch + 1) % 48;
      rsp_ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks the response first, then predicts the newly taken item, so
  // a stray response can never consume an expectation made on the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cache_req_t r;
    cache_rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        tag_dev[i]  = '0;
        tag_blk[i]  = 32'(i);
        ent_vld[i]  = 1'b0;
        ref_cnt[i]  = '0;
        rel_time[i] = '0;
      end
      due_rsp_q.delete();
      n_checked <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_rsp_q.size() == 0) begin
          if (err_cnt < 10)
            $display("UNEXPECTED response: entry_index %0d hit %0d needs_fill %0d status %0d",
                     entry_index, hit, needs_fill, status);
          err_cnt++;
        end else begin
          want = due_rsp_q.pop_front();
          check_field("entry_index", 32'(want.entry), 32'(entry_index));
          check_field("hit",         32'(want.hit),   32'(hit));
          check_field("needs_fill",  32'(want.fill),  32'(needs_fill));
          check_field("status",      32'(want.st),    32'(status));
          if (want.hit)          n_hit++;
          if (want.fill)         n_fill++;
          if (want.st == ST_FULL)  n_full++;
          if (want.st == ST_UNDER) n_under++;
        end
        n_checked <= n_checked + 1;
      end
      if (req_valid && req_ready) begin
        r.op   = op;
        r.dev  = device;
        r.blk  = block_number;
        r.idx  = buffer_index;
        r.tick = now_tick;
        due_rsp_q.push_back(directory_step(r));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [1:0] o, logic [7:0] d, logic [31:0] b, int e,
                            logic [31:0] t);
    cache_req_t it;
    it.op   = o;
    it.dev  = d;
    it.blk  = b;
    it.idx  = 6'(e);
    it.tick = t;
    req_q.push_back(it);
    n_items++;
  endtask

  // The sender holds back until every owed response has been consumed.
  task automatic wait_idle();
    while (req_q.size() != 0 || req_valid || due_rsp_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int          phase;
    int          sel;
    int          j;
    int          e;
    int          sat_idx;
    int          n_free;
    logic [1:0]  o;
    logic [7:0]  d;
    logic [31:0] b;
    logic [31:0] t;
    int          held [$];
    logic [39:0] recent [$];

    n_items  = 0;
    err_cnt  = 0;
    n_hit    = 0;
    n_fill   = 0;
    n_full   = 0;
    n_under  = 0;
    n_sat    = 0;
    cur_tick = 32'd1000;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: hits on never-written entries, tie breaks, stamps at both tick
    // extremes, underflow on release and unpin, field extremes.
    queue_item(OP_READ,    8'h00, 32'd5,          0,  '0);   // hit, entry not valid
    queue_item(OP_READ,    8'h00, 32'd5,          63, '1);   // hit, now valid
    queue_item(OP_READ,    8'hFF, 32'hFFFF_FFFF,  0,  '0);   // miss, lowest free
    queue_item(OP_READ,    8'h00, 32'd0,          0,  '0);   // entry 0 was retagged
    queue_item(OP_READ,    8'hA5, 32'h5A5A_5A5A,  42, '0);
    queue_item(OP_PIN,     8'h00, 32'd0,          63, '0);
    queue_item(OP_UNPIN,   8'h00, 32'd0,          63, '0);
    queue_item(OP_UNPIN,   8'hFF, 32'hFFFF_FFFF,  63, '1);   // underflow
    queue_item(OP_RELEASE, 8'h00, 32'd0,          63, '1);   // underflow, no stamp
    queue_item(OP_RELEASE, 8'h00, 32'd0,          5,  '1);   // 2 -> 1
    queue_item(OP_RELEASE, 8'h00, 32'd0,          5,  '1);   // final release, max tick
    queue_item(OP_RELEASE, 8'h00, 32'd0,          0,  '0);   // stamp zero
    queue_item(OP_RELEASE, 8'h00, 32'd0,          1,  100);
    queue_item(OP_READ,    8'h3C, 32'd0,          0,  '0);   // oldest free wins
    queue_item(OP_READ,    8'h00, 32'd5,          0,  '0);   // hit on a released entry
    queue_item(OP_PIN,     8'h00, 32'd0,          0,  '0);
    queue_item(OP_RELEASE, 8'h00, 32'd0,          0,  7);
    queue_item(OP_RELEASE, 8'h00, 32'd0,          0,  7);
    queue_item(OP_READ,    8'h12, 32'h34,         21, '0);
    queue_item(OP_RELEASE, 8'h00, 32'd0,          2,  32'h8000_0000);
    queue_item(OP_READ,    8'h00, 32'd63,         0,  '0);   // reset tag of last entry
    queue_item(OP_UNPIN,   8'h00, 32'd0,          63, '0);   // to zero, no stamp
    wait_idle();

    phase = 1;
    while (n_items < ITEMS) begin
      if (phase == 3) begin
        // drive one entry's refcount past its ceiling
        sat_idx = $urandom_range(0, NUM_ENTRIES - 1);
        for (int k = 0; k < 257; k++)
          queue_item(OP_PIN, 8'($urandom), $urandom, sat_idx, $urandom);
        for (int k = 0; k < 3; k++)
          queue_item(OP_UNPIN, 8'($urandom), $urandom, sat_idx, $urandom);
      end else if (phase % 12 == 6) begin
        // fresh tags until every entry is held, then a few reads with none free
        n_free = 0;
        for (int i = 0; i < NUM_ENTRIES; i++) if (ref_cnt[i] == 8'd0) n_free++;
        for (int k = 0; k < n_free + 3; k++)
          queue_item(OP_READ, 8'($urandom), $urandom, $urandom_range(0, 63), $urandom);
      end else if (phase % 12 == 7) begin
        // free nearly everything on one shared tick (the largest one the first
        // time), then reads must break the tie on the lowest index
        t = (phase < 12) ? 32'hFFFF_FFFF : $urandom;
        held.delete();
        for (int i = 0; i < NUM_ENTRIES; i++)
          if (ref_cnt[i] <= 8'd6)
            for (int k = 0; k < int'(ref_cnt[i]); k++) held.push_back(i);
        while (held.size() != 0) begin
          j = $urandom_range(0, held.size() - 1);
          queue_item(OP_RELEASE, 8'($urandom), $urandom, held[j], t);
          held.delete(j);
        end
        for (int k = 0; k < 10; k++)
          queue_item(OP_READ, 8'($urandom), $urandom, $urandom_range(0, 63), $urandom);
      end else begin
        // Mixed traffic. Releases and unpins mostly return references that are
        // actually held, reads mostly revisit known tags; the rest is noise.
        held.delete();
        for (int i = 0; i < NUM_ENTRIES; i++)
          for (int k = 0; k < int'(ref_cnt[i]) && k < 3; k++) held.push_back(i);
        for (int k = 0; k < MIX_LEN; k++) begin
          case ($urandom_range(0, 39))
            0:             cur_tick = '0;
            1:             cur_tick = '1;
            2:             cur_tick = $urandom;
            3, 4, 5, 6, 7: cur_tick = cur_tick + $urandom_range(1, 5000);
            default:       ;   // tick held, so stamps tie
          endcase
          sel = $urandom_range(0, 99);
          if (sel < 35) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
              j = $urandom_range(0, NUM_ENTRIES - 1);
              d = tag_dev[j];
              b = tag_blk[j];
            end else if (sel < 50) begin
              d = 8'h00;
              b = $urandom_range(0, NUM_ENTRIES - 1);
            end else if (sel < 65 && recent.size() != 0) begin
              {d, b} = recent[$urandom_range(0, recent.size() - 1)];
            end else begin
              d = 8'($urandom);
              b = $urandom;
              recent.push_back({d, b});
              if (recent.size() > 8) void'(recent.pop_front());
            end
            queue_item(OP_READ, d, b, $urandom_range(0, 63), cur_tick);
          end else if (sel < 88) begin
            o = (sel < 70) ? OP_RELEASE : (sel < 78) ? OP_PIN : OP_UNPIN;
            if (held.size() != 0) begin
              j = $urandom_range(0, held.size() - 1);
              e = held[j];
              if (o != OP_PIN) held.delete(j);
            end else begin
              e = $urandom_range(0, NUM_ENTRIES - 1);
            end
            queue_item(o, 8'($urandom), $urandom, e, cur_tick);
          end else begin
            o = ($urandom_range(0, 1) == 0) ? OP_RELEASE : OP_UNPIN;
            queue_item(o, 8'($urandom), $urandom, $urandom_range(0, 63), cur_tick);
          end
        end
      end
      wait_idle();
      phase++;
    end

    // a read is the longest operation: one scan of the directory plus the drain and final steps
    repeat (NUM_ENTRIES + 20) @(posedge clk);
    if (due_rsp_q.size() != 0) begin
      $display("%0d responses never arrived", due_rsp_q.size());
      err_cnt += due_rsp_q.size();
    end

    $display("Ran %0d items in %0d phases: %0d hits, %0d fills, %0d with no free entry,",
             n_items, phase, n_hit, n_fill, n_full);
    $display("%0d refcount underflows, %0d saturated increments, %0d mismatches",
             n_under, n_sat, err_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost response ends here.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Run stopped at the %0d-cycle limit", CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_ram.sv
hw/rtl/bbc_scan.sv
hw/rtl/block_buffer_cache_lru.sv
verif/tb.sv
